>>> hw/rtl/mvc_pkg.sv
// mvc_pkg: shared types and constants of the multi-voice chorus
// register indexes, register reset values, sequencer states and status group
`timescale 1ns / 1ps

package mvc_pkg;

	localparam int CFG_DATA_W  = 32;
	localparam int CFG_INDEX_W = 2;
	localparam int STEP_W      = 32;
	localparam int DELAY_W     = 20;
	localparam int MIX_W       = 16;

	localparam logic [STEP_W-1:0]  STEP_RST  = 32'd89478;
	localparam logic [DELAY_W-1:0] BASE_RST  = 20'd61440;
	localparam logic [DELAY_W-1:0] DEPTH_RST = 20'd24576;
	localparam logic [MIX_W-1:0]   MIX_RST   = 16'd16384;
	localparam logic [16:0]        MIX_FULL  = 17'd32768;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_PHASE_STEP = 2'd0,
		CFG_BASE_DELAY = 2'd1,
		CFG_MOD_DEPTH  = 2'd2,
		CFG_WET_MIX    = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [STEP_W-1:0]  phase_step;
		logic [DELAY_W-1:0] base_delay;
		logic [DELAY_W-1:0] mod_depth;
		logic [MIX_W-1:0]   wet_mix;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SINE,
		ST_MUL,
		ST_DLY,
		ST_POS,
		ST_RD0,
		ST_RD1,
		ST_ACC,
		ST_WET,
		ST_DVLD,
		ST_DIV,
		ST_SUM,
		ST_DONE
	} back_state_t;

	typedef struct packed {
		logic clearing;
		logic busy;
	} status_t;

endpackage

>>> hw/rtl/mvc_dry_if.sv
// mvc_dry_if: valid/ready channel carrying one dry sample per beat
// no dependencies
`timescale 1ns / 1ps

interface mvc_dry_if #(
	parameter int SAMPLE_WIDTH = 16
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] dry_sample;

	modport source(output valid, output dry_sample, input ready);
	modport sink(input valid, input dry_sample, output ready);
endinterface

>>> hw/rtl/mvc_mixed_if.sv
// mvc_mixed_if: valid/ready channel carrying one mixed sample per beat
// no dependencies
`timescale 1ns / 1ps

interface mvc_mixed_if #(
	parameter int SAMPLE_WIDTH = 16
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] mixed_sample;

	modport source(output valid, output mixed_sample, input ready);
	modport sink(input valid, input mixed_sample, output ready);
endinterface

>>> hw/rtl/mvc_front.sv
// mvc_front: input side, takes dry beats into a two-entry queue
// depends on mvc_pkg and mvc_dry_if; held off while the delay line is cleared
`timescale 1ns / 1ps

module mvc_front #(
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  mvc_pkg::status_t status,
	mvc_dry_if.sink          dry_chan,
	mvc_dry_if.source        job
);
	import mvc_pkg::*;

	logic signed [SAMPLE_WIDTH-1:0] slot_q [2];
	logic                           wr_ptr_q;
	logic                           rd_ptr_q;
	logic [1:0]                     count_q;
	logic                           push;
	logic                           pop;

	assign dry_chan.ready = (count_q != 2'd2) && !status.clearing;
	assign push           = dry_chan.valid && dry_chan.ready;
	assign job.valid      = (count_q != 2'd0);
	assign job.dry_sample = slot_q[rd_ptr_q];
	assign pop            = job.valid && job.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= dry_chan.dry_sample;
	end

endmodule

>>> hw/rtl/mvc_back.sv
// mvc_back: delay line, sine table, per-voice sequencer, mixer and output register
// depends on mvc_pkg, mvc_dry_if and mvc_mixed_if
`timescale 1ns / 1ps

module mvc_back #(
	parameter int DELAY_DEPTH    = 4096,
	parameter int VOICES         = 3,
	parameter int SAMPLE_WIDTH   = 16,
	parameter int SINE_ADDR_BITS = 10
) (
	input  logic              clk,
	input  logic              arst_n,
	input  mvc_pkg::cfg_t     cfg,
	output mvc_pkg::status_t  status,
	mvc_dry_if.sink           job,
	mvc_mixed_if.source       mixed_chan
);
	import mvc_pkg::*;

	localparam int SW        = SAMPLE_WIDTH;
	localparam int AW        = $clog2(DELAY_DEPTH);
	localparam int VW        = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int TOTAL     = DELAY_DEPTH * 256;
	localparam int PW        = $clog2(TOTAL) + 1;
	localparam int DW        = ((PW > 21) ? PW : 21) + 2;
	localparam int IW        = SW + 10;
	localparam int WW        = SW + 12;
	localparam int BW        = WW + 10;
	localparam int DRYW      = SW + 18;
	localparam int ZW        = BW + 4;
	localparam int NW        = SW + 8;
	localparam int KW        = NW + 3;
	localparam int RW        = KW + 1;
	localparam int PRW       = NW + RW;
	localparam int QW        = NW + 1;
	localparam int SINE_SIZE = 1 << SINE_ADDR_BITS;
	localparam int QUARTER   = SINE_SIZE / 4;

	localparam logic signed [DW-1:0] DMIN  = DW'(256);
	localparam logic signed [DW-1:0] DMAX  = DW'(TOTAL - 256);
	localparam logic [NW-1:0]        NOFF  = NW'(VOICES) << (SW + 4);
	localparam logic [RW-1:0]        RECIP =
		RW'(((64'd1 << KW) + 64'(VOICES) - 64'd1) / 64'(VOICES));
	localparam logic signed [QW-1:0] QOFF  = QW'(1) << (SW + 4);
	localparam logic signed [QW-1:0] MAXV  = {{(QW-SW+1){1'b0}}, {(SW-1){1'b1}}};
	localparam logic signed [QW-1:0] MINV  = ~MAXV;

	function automatic logic [63:0] sin_q30(input logic [63:0] x);
		logic [63:0] one;
		logic [63:0] x2;
		logic [63:0] t;
		one = 64'd1 << 30;
		x2  = (x * x) >> 30;
		t   = one - (x2 / 64'd110);
		t   = one - ((x2 * t) >> 30) / 64'd72;
		t   = one - ((x2 * t) >> 30) / 64'd42;
		t   = one - ((x2 * t) >> 30) / 64'd20;
		t   = one - ((x2 * t) >> 30) / 64'd6;
		return (x * t) >> 30;
	endfunction

	function automatic logic [15:0] quarter_sine(input int unsigned i);
		logic [63:0] x;
		logic [63:0] v;
		x = (64'(i) * 64'd1686629713) / QUARTER;
		v = (sin_q30(x) + 64'd16384) >> 15;
		if (v > 64'd32767) v = 64'd32767;
		return v[15:0];
	endfunction

	function automatic logic [SINE_SIZE*16-1:0] build_sine();
		logic [SINE_SIZE*16-1:0] tab;
		int unsigned             q;
		int unsigned             r;
		logic [15:0]             v;
		tab = '0;
		for (int unsigned i = 0; i < SINE_SIZE; i++) begin
			q = i / QUARTER;
			r = i % QUARTER;
			if (q == 0) v = quarter_sine(r);
			else if (q == 1) v = quarter_sine(QUARTER - r);
			else if (q == 2) v = -quarter_sine(r);
			else v = -quarter_sine(QUARTER - r);
			tab[i*16 +: 16] = v;
		end
		return tab;
	endfunction

	function automatic logic [31:0] phase_init(input int v);
		return 32'((64'(v) << 32) / VOICES);
	endfunction

	localparam logic [SINE_SIZE*16-1:0] SINE_TAB = build_sine();

	// control
	back_state_t       state_q;
	back_state_t       state_d;
	logic [AW-1:0]     wp_q;
	logic [AW-1:0]     clr_q;
	logic [VW-1:0]     v_q;
	logic              out_valid_q;
	logic [31:0]       phase_q [VOICES];
	logic              last_voice;
	logic              out_load;

	// memory ports
	logic signed [SW-1:0] line_mem [DELAY_DEPTH];
	logic                 mem_we;
	logic [AW-1:0]        mem_waddr;
	logic signed [SW-1:0] mem_wdata;
	logic [AW-1:0]        mem_raddr;
	logic signed [SW-1:0] rdata_q;

	// datapath
	logic signed [SW-1:0]   dry_q;
	logic signed [15:0]     sine_q;
	logic signed [36:0]     prod_q;
	logic [PW-1:0]          dly_q;
	logic [AW-1:0]          i0_q;
	logic [AW-1:0]          i1_q;
	logic [7:0]             fr_q;
	logic signed [IW-1:0]   p0_q;
	logic signed [WW-1:0]   acc_q;
	logic signed [WW+17:0]  b_q;
	logic signed [DRYW-1:0] a_q;
	logic signed [BW-1:0]   w_q;
	logic [NW-1:0]          num_q;
	logic [NW-1:0]          quo_q;
	logic signed [SW-1:0]   out_q;

	logic [SINE_ADDR_BITS-1:0] sine_idx;
	logic signed [21:0]        swing;
	logic signed [DW-1:0]      dv;
	logic [PW-1:0]             posv;
	logic [AW-1:0]             i0;
	logic signed [IW-1:0]      p1;
	logic [16:0]               mix_c;
	logic signed [ZW-1:0]      zsum;
	logic [PRW-1:0]            rprod;
	logic signed [QW-1:0]      res_full;
	logic signed [SW-1:0]      res_sat;

	assign last_voice = (v_q == VW'(VOICES - 1));
	assign out_load   = (state_q == ST_DONE) && (!out_valid_q || mixed_chan.ready);
	assign mix_c      = (17'(cfg.wet_mix) > MIX_FULL) ? MIX_FULL : 17'(cfg.wet_mix);
	assign sine_idx   = phase_q[v_q][31 -: SINE_ADDR_BITS];

	assign mixed_chan.valid        = out_valid_q;
	assign mixed_chan.mixed_sample = out_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (clr_q == AW'(DELAY_DEPTH - 1)) state_d = ST_IDLE;
			ST_IDLE:  if (job.valid) state_d = ST_SINE;
			ST_SINE:  state_d = ST_MUL;
			ST_MUL:   state_d = ST_DLY;
			ST_DLY:   state_d = ST_POS;
			ST_POS:   state_d = ST_RD0;
			ST_RD0:   state_d = ST_RD1;
			ST_RD1:   state_d = ST_ACC;
			ST_ACC:   state_d = last_voice ? ST_WET : ST_SINE;
			ST_WET:   state_d = ST_DVLD;
			ST_DVLD:  state_d = ST_DIV;
			ST_DIV:   state_d = ST_SUM;
			ST_SUM:   state_d = ST_DONE;
			ST_DONE:  if (out_load) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		job.ready       = 1'b0;
		mem_we          = 1'b0;
		mem_waddr       = wp_q;
		mem_wdata       = job.dry_sample;
		mem_raddr       = i0_q;
		status.clearing = 1'b0;
		status.busy     = 1'b1;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we          = 1'b1;
				mem_waddr       = clr_q;
				mem_wdata       = '0;
				status.clearing = 1'b1;
				status.busy     = 1'b0;
			end
			ST_IDLE: begin
				job.ready   = 1'b1;
				mem_we      = job.valid;
				status.busy = 1'b0;
			end
			ST_RD1:  mem_raddr = i1_q;
			default: mem_raddr = i0_q;
		endcase
	end

	// delay and read position
	always_comb begin
		swing = 22'((prod_q + 37'sd16384) >>> 15);
		dv    = DW'($signed({1'b0, cfg.base_delay})) + DW'(swing);
		posv  = PW'({wp_q, 8'b0}) + PW'(TOTAL) - dly_q;
		if (posv >= PW'(TOTAL)) posv = posv - PW'(TOTAL);
		i0    = posv[AW+7:8];
		p1    = rdata_q * $signed({2'b0, fr_q});
	end

	// voice average by reciprocal multiplication, offset keeps the dividend positive
	always_comb begin
		zsum     = (ZW'(a_q) + ZW'(16384)) * ZW'(VOICES) + ZW'(w_q);
		rprod    = PRW'(num_q) * PRW'(RECIP);
		res_full = $signed({1'b0, quo_q}) - QOFF;
		if (res_full > MAXV) res_sat = MAXV[SW-1:0];
		else if (res_full < MINV) res_sat = MINV[SW-1:0];
		else res_sat = res_full[SW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			wp_q        <= '0;
			clr_q       <= '0;
			v_q         <= '0;
			out_valid_q <= 1'b0;
			for (int v = 0; v < VOICES; v++) phase_q[v] <= phase_init(v);
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + AW'(1);
			if (state_q == ST_IDLE) v_q <= '0;
			if (state_q == ST_ACC) begin
				phase_q[v_q] <= phase_q[v_q] + cfg.phase_step;
				v_q          <= v_q + VW'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
				wp_q        <= (wp_q == AW'(DELAY_DEPTH - 1)) ? '0 : wp_q + AW'(1);
			end else if (mixed_chan.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) line_mem[mem_waddr] <= mem_wdata;
		rdata_q <= line_mem[mem_raddr];
	end

	always_ff @(posedge clk) begin
		sine_q <= $signed(SINE_TAB[{sine_idx, 4'b0} +: 16]);
		unique case (state_q)
			ST_IDLE: begin
				dry_q <= job.dry_sample;
				acc_q <= '0;
			end
			ST_MUL: prod_q <= $signed({1'b0, cfg.mod_depth}) * sine_q;
			ST_DLY: begin
				if (dv < DMIN) dly_q <= DMIN[PW-1:0];
				else if (dv > DMAX) dly_q <= DMAX[PW-1:0];
				else dly_q <= dv[PW-1:0];
			end
			ST_POS: begin
				i0_q <= i0;
				i1_q <= (i0 == AW'(DELAY_DEPTH - 1)) ? '0 : i0 + AW'(1);
				fr_q <= posv[7:0];
			end
			ST_RD1: p0_q <= rdata_q * $signed({1'b0, 9'(16'd256 - 16'(fr_q))});
			ST_ACC: acc_q <= acc_q + WW'(p0_q) + WW'(p1);
			ST_WET: b_q <= acc_q * $signed({1'b0, mix_c});
			ST_DVLD: begin
				w_q <= BW'(b_q >>> 8);
				a_q <= dry_q * $signed({1'b0, MIX_FULL - mix_c});
			end
			ST_DIV: num_q <= NW'(zsum >>> 15) + NOFF;
			ST_SUM: quo_q <= rprod[KW +: NW];
			default: ;
		endcase
		if (out_load) out_q <= res_sat;
	end

endmodule

>>> hw/rtl/multi_voice_chorus.sv
// multi_voice_chorus: lfo-modulated multi-voice chorus, top level with config registers
// one beat at a time; the per-voice sequencer, stepping through the voices in turn, sets the throughput
// a result waiting in the output register does not block the next beat until it reaches ST_DONE
// after reset the delay line is cleared entry by entry, with the input held off
`timescale 1ns / 1ps

module multi_voice_chorus #(
	parameter int DELAY_DEPTH    = 4096,
	parameter int VOICES         = 3,
	parameter int SAMPLE_WIDTH   = 16,
	parameter int SINE_ADDR_BITS = 10
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	mvc_dry_if.sink                               dry_chan,
	mvc_mixed_if.source                           mixed_chan,
	input  logic                                  cfg_we,
	input  mvc_pkg::cfg_idx_t                     cfg_index,
	input  logic [mvc_pkg::CFG_DATA_W-1:0]        cfg_wdata
);
	import mvc_pkg::*;

	cfg_t    cfg_q;
	status_t status;

	mvc_dry_if #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) job_if ();

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.phase_step <= STEP_RST;
			cfg_q.base_delay <= BASE_RST;
			cfg_q.mod_depth  <= DEPTH_RST;
			cfg_q.wet_mix    <= MIX_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PHASE_STEP: cfg_q.phase_step <= cfg_wdata[STEP_W-1:0];
				CFG_BASE_DELAY: cfg_q.base_delay <= cfg_wdata[DELAY_W-1:0];
				CFG_MOD_DEPTH:  cfg_q.mod_depth  <= cfg_wdata[DELAY_W-1:0];
				CFG_WET_MIX:    cfg_q.wet_mix    <= cfg_wdata[MIX_W-1:0];
				default: ;
			endcase
		end
	end

	mvc_front #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.status   (status),
		.dry_chan (dry_chan),
		.job      (job_if.source)
	);

	mvc_back #(
		.DELAY_DEPTH    (DELAY_DEPTH),
		.VOICES         (VOICES),
		.SAMPLE_WIDTH   (SAMPLE_WIDTH),
		.SINE_ADDR_BITS (SINE_ADDR_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.status     (status),
		.job        (job_if.sink),
		.mixed_chan (mixed_chan)
	);

	a_no_beat_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		status.clearing |-> !dry_chan.ready)
		else $error("input ready during delay line clear");

	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(mixed_chan.valid) |-> $past(status.busy))
		else $error("result appeared without a beat in work");

	a_clear_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!(status.clearing && status.busy))
		else $error("sequencer busy during clear");

endmodule
